### rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants, register codes and types for the touch-to-screen unit.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int ADC_BITS   = 12;
    localparam int COORD_W    = 12;
    localparam int PRESS_W    = 13;
    localparam int NUM_W      = 2 * COORD_W;      // |raw - min| * (size - 1)
    localparam int QUOT_W     = COORD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int ORIENT_W   = 2;

    localparam logic [ADC_BITS-1:0] ADC_MAX  = {ADC_BITS{1'b1}};
    localparam logic [COORD_W-1:0]  RAW_LOW  = 12'd100;
    localparam logic [COORD_W-1:0]  RAW_HIGH = 12'd4000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR   = 3'd6;

    // register reset values
    localparam logic [COORD_W-1:0] RST_CAL_MIN = 12'd200;
    localparam logic [COORD_W-1:0] RST_CAL_MAX = 12'd3900;
    localparam logic [COORD_W-1:0] RST_SCREEN_W = 12'd320;
    localparam logic [COORD_W-1:0] RST_SCREEN_H = 12'd240;
    localparam logic [PRESS_W-1:0] RST_PRESS_THR = 13'd250;

    // orientation codes
    localparam logic [ORIENT_W-1:0] ORIENT_PORTRAIT   = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_LAND_LEFT  = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_LAND_RIGHT = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 2;

    // one axis worth of divide work
    typedef struct packed {
        logic [NUM_W-1:0]   num;        // |raw - min| * top
        logic [COORD_W-1:0] span;       // |max - min|
        logic [COORD_W-1:0] top;        // size - 1 (size 0 as 1)
        logic               mirror;
        logic               force_zero; // zero span or negative quotient
    } axis_op_t;

    typedef struct packed {
        logic     touched;
        axis_op_t ax_x;
        axis_op_t ax_y;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } bk_state_t;

endpackage

### rtl/core/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Register file, pressure gate and per-axis operand setup (offset * top).
// ----------------------------------------------------------------------------
module tsc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [tsc_pkg::COORD_W-1:0]    z1_reading,
    input  logic [tsc_pkg::COORD_W-1:0]    z2_reading,
    input  logic [tsc_pkg::COORD_W-1:0]    raw_x,
    input  logic [tsc_pkg::COORD_W-1:0]    raw_y,
    input  logic [tsc_pkg::ORIENT_W-1:0]   orientation,
    output tsc_pkg::job_t                  job
);
    import tsc_pkg::*;

    logic [COORD_W-1:0] cal_min_x_reg, cal_max_x_reg, cal_min_y_reg, cal_max_y_reg;
    logic [COORD_W-1:0] screen_w_reg, screen_h_reg;
    logic [PRESS_W-1:0] press_thr_reg;

    logic [PRESS_W:0]   pressure;
    logic               in_range;
    logic               mirror_land;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_min_x_reg <= RST_CAL_MIN;
            cal_max_x_reg <= RST_CAL_MAX;
            cal_min_y_reg <= RST_CAL_MIN;
            cal_max_y_reg <= RST_CAL_MAX;
            screen_w_reg  <= RST_SCREEN_W;
            screen_h_reg  <= RST_SCREEN_H;
            press_thr_reg <= RST_PRESS_THR;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CAL_MIN_X: cal_min_x_reg <= cfg_wdata[COORD_W-1:0];
                REG_CAL_MAX_X: cal_max_x_reg <= cfg_wdata[COORD_W-1:0];
                REG_CAL_MIN_Y: cal_min_y_reg <= cfg_wdata[COORD_W-1:0];
                REG_CAL_MAX_Y: cal_max_y_reg <= cfg_wdata[COORD_W-1:0];
                REG_SCREEN_W:  screen_w_reg  <= cfg_wdata[COORD_W-1:0];
                REG_SCREEN_H:  screen_h_reg  <= cfg_wdata[COORD_W-1:0];
                REG_PRESS_THR: press_thr_reg <= cfg_wdata;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // Sign handling up front: a negative quotient always clamps to 0, so the
    // back end only ever divides magnitudes.
    function automatic axis_op_t axis_setup(
        input logic [COORD_W-1:0] raw,
        input logic [COORD_W-1:0] lo,
        input logic [COORD_W-1:0] hi,
        input logic [COORD_W-1:0] size,
        input logic               mirror
    );
        logic signed [COORD_W:0] diff;
        logic signed [COORD_W:0] span;
        logic [COORD_W:0]        diff_mag;
        logic [COORD_W:0]        span_mag;
        logic [COORD_W-1:0]      top;
        axis_op_t                op;
        diff     = $signed({1'b0, raw}) - $signed({1'b0, lo});
        span     = $signed({1'b0, hi}) - $signed({1'b0, lo});
        diff_mag = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
        span_mag = span[COORD_W] ? (COORD_W+1)'(-span) : span;
        top      = (size == '0) ? '0 : size - 1'b1;
        op.num        = diff_mag[COORD_W-1:0] * top;
        op.span       = span_mag[COORD_W-1:0];
        op.top        = top;
        op.mirror     = mirror;
        op.force_zero = (span == '0) || (diff[COORD_W] ^ span[COORD_W]);
        return op;
    endfunction

    assign pressure    = (PRESS_W+1)'(ADC_MAX) + (PRESS_W+1)'(z1_reading)
                         - (PRESS_W+1)'(z2_reading);
    assign in_range    = (raw_x >= RAW_LOW) && (raw_x <= RAW_HIGH) &&
                         (raw_y >= RAW_LOW) && (raw_y <= RAW_HIGH);
    assign mirror_land = (orientation != ORIENT_LAND_RIGHT);

    always_comb begin
        job.touched = (pressure > (PRESS_W+1)'(press_thr_reg)) && in_range;
        if (orientation == ORIENT_PORTRAIT) begin
            job.ax_x = axis_setup(raw_x, cal_min_x_reg, cal_max_x_reg, screen_w_reg, 1'b1);
            job.ax_y = axis_setup(raw_y, cal_min_y_reg, cal_max_y_reg, screen_h_reg, 1'b0);
        end else begin
            job.ax_x = axis_setup(raw_y, cal_min_y_reg, cal_max_y_reg, screen_w_reg,
                                  mirror_land);
            job.ax_y = axis_setup(raw_x, cal_min_x_reg, cal_max_x_reg, screen_h_reg,
                                  mirror_land);
        end
    end

endmodule

### rtl/core/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// Small register FIFO of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module tsc_queue #(
    parameter int DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tsc_pkg::job_t       push_job,
    input  logic                pop,
    output tsc_pkg::job_t       head_job,
    output tsc_pkg::q_status_t  status
);
    import tsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/core/tsc_div_lane.sv
// ----------------------------------------------------------------------------
// tsc_div_lane
// Restoring divider, one quotient bit per step, with clamp and mirror.
// ----------------------------------------------------------------------------
module tsc_div_lane (
    input  logic                        aclk,
    input  logic                        load,
    input  logic                        step,
    input  tsc_pkg::axis_op_t           op,
    output logic [tsc_pkg::COORD_W-1:0] result
);
    import tsc_pkg::*;

    logic [QUOT_W-1:0]  low_reg;    // dividend bits still to shift in
    logic [COORD_W-1:0] rem_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [COORD_W-1:0] span_reg;
    logic [COORD_W-1:0] top_reg;
    logic               mirror_reg;
    logic               zero_reg;
    logic               sat_reg;

    logic [COORD_W:0]   trial;
    logic               fits;
    logic [COORD_W-1:0] clamped;

    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign fits  = (trial >= {1'b0, span_reg});

    always_ff @(posedge aclk) begin
        if (load) begin
            low_reg    <= op.num[QUOT_W-1:0];
            rem_reg    <= op.num[NUM_W-1:QUOT_W];
            quot_reg   <= '0;
            span_reg   <= op.span;
            top_reg    <= op.top;
            mirror_reg <= op.mirror;
            zero_reg   <= op.force_zero;
            // quotient of 2^QUOT_W or more clamps to top unless force_zero is set
            sat_reg    <= ({1'b0, op.num} >= {1'b0, op.span, {QUOT_W{1'b0}}});
        end else if (step) begin
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            rem_reg  <= fits ? COORD_W'(trial - {1'b0, span_reg}) : trial[COORD_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    always_comb begin
        if (zero_reg) begin
            clamped = '0;
        end else if (sat_reg || (quot_reg > top_reg)) begin
            clamped = top_reg;
        end else begin
            clamped = quot_reg;
        end
        result = mirror_reg ? top_reg - clamped : clamped;
    end

endmodule

### rtl/core/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// Pops jobs, runs both axis dividers in lockstep, holds the result register.
// ----------------------------------------------------------------------------
module tsc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tsc_pkg::job_t               head_job,
    input  tsc_pkg::q_status_t          q_status,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tsc_pkg::COORD_W-1:0] screen_x,
    output logic [tsc_pkg::COORD_W-1:0] screen_y,
    output logic                        touched
);
    import tsc_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    bk_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   step_cnt_reg, step_cnt_next;
    logic               job_touch_reg;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic               out_touch_reg;
    logic               step;
    logic               emit;
    logic [COORD_W-1:0] lane_x, lane_y;

    tsc_div_lane u_lane_x (
        .aclk   (aclk),
        .load   (pop),
        .step   (step),
        .op     (head_job.ax_x),
        .result (lane_x)
    );

    tsc_div_lane u_lane_y (
        .aclk   (aclk),
        .load   (pop),
        .step   (step),
        .op     (head_job.ax_y),
        .result (lane_y)
    );

    always_comb begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        pop            = 1'b0;
        step           = 1'b0;
        emit           = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    pop           = 1'b1;
                    step_cnt_next = '0;
                    state_next    = BK_RUN;
                end
            end
            BK_RUN: begin
                step          = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST_STEP) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_touch_reg <= head_job.touched;
        end
        if (emit) begin
            out_touch_reg <= job_touch_reg;
            out_x_reg     <= job_touch_reg ? lane_x : '0;
            out_y_reg     <= job_touch_reg ? lane_y : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign screen_x = out_x_reg;
    assign screen_y = out_y_reg;
    assign touched  = out_touch_reg;

endmodule

### rtl/core/touch_sample_to_screen_coord_unit.sv
// ----------------------------------------------------------------------------
// touch_sample_to_screen_coord_unit
// Resistive touch pressure gate and linear screen calibration.
// ----------------------------------------------------------------------------
// One input transfer carries Z1, Z2, raw X and raw Y readings plus the screen
// orientation; exactly one result transfer comes back for each, in order.
// Pressure (4095 + Z1 - Z2) must exceed pressure_threshold and both raw axes
// must sit in 100..4000, otherwise the result is touched=0 with zero coords.
// A touch maps each axis as (raw - min) * (size - 1) / (max - min), truncated
// toward zero, clamped to 0..size-1, then mirrored per orientation (portrait
// mirrors X; landscape swaps axes and mirrors both, except landscape right).
// Timing: the front end registers the scaled operands into a job queue (two
// entries by default) in the accept cycle; the back end runs two 12-step
// restoring dividers side by side, one quotient bit per step, and pops the
// next job only after the last result has been loaded into the output register.
// The input side keeps taking transfers while the queue has room, even with
// a result waiting on m_tready.
// Configuration is through cfg_we/cfg_index/cfg_wdata; write only when idle.
// ----------------------------------------------------------------------------
module touch_sample_to_screen_coord_unit #(
    parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // sample input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,  // z1[11:0] z2[23:12] x[35:24] y[47:36]
    input  logic [1:0]                     s_tuser,  // orientation[1:0]
    // coordinate output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,  // screen_x[11:0] screen_y[23:12]
    output logic                           m_tuser   // touched[0]
);
    import tsc_pkg::*;

    job_t               front_job;
    job_t               head_job;
    q_status_t          q_status;
    logic               q_push;
    logic               q_pop;
    logic [COORD_W-1:0] screen_x, screen_y;

    // input transfer goes straight into the job queue
    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && s_tready;

    tsc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .z1_reading  (s_tdata[11:0]),
        .z2_reading  (s_tdata[23:12]),
        .raw_x       (s_tdata[35:24]),
        .raw_y       (s_tdata[47:36]),
        .orientation (s_tuser),
        .job         (front_job)
    );

    tsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    tsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .touched  (m_tuser)
    );

    assign m_tdata = {screen_y, screen_x};

`ifndef SYNTHESIS
    // a rejected sample reports the origin
    a_notouch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("untouched result carries nonzero coordinates");

    // the back end never takes a job from an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    // nothing to show right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid directly after reset");
`endif

endmodule
